### hdl/integrator_with_trigger_reset_assert.svh
// Assertion macros for the integrator block.
// IMP: same-cycle implication, NXT: next-cycle implication.
// Both are disabled while the asynchronous reset is low.
`ifndef INTEGRATOR_WITH_TRIGGER_RESET_ASSERT_SVH
`define INTEGRATOR_WITH_TRIGGER_RESET_ASSERT_SVH

`define ITR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("itr: same-cycle check failed");

`define ITR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("itr: next-cycle check failed");

`endif

### hdl/itr_pkg.sv
package itr_pkg;

	// command codes (tuser of the input stream)
	localparam logic [1:0] CMD_STEP = 2'd0;
	localparam logic [1:0] CMD_HOLD = 2'd1;
	localparam logic [1:0] CMD_INIT = 2'd2;

	// trigger reset modes
	localparam logic [1:0] RM_LEVEL = 2'd0;
	localparam logic [1:0] RM_RISE  = 2'd1;
	localparam logic [1:0] RM_FALL  = 2'd2;

	// register indexes (byte address = 4 * index)
	localparam logic [2:0] REG_RESET_MODE  = 3'd0;
	localparam logic [2:0] REG_RESET_VALUE = 3'd1;
	localparam logic [2:0] REG_GAIN_STEP   = 3'd2;
	localparam logic [2:0] REG_LOWER_LIMIT = 3'd3;
	localparam logic [2:0] REG_UPPER_LIMIT = 3'd4;
	localparam logic [2:0] REG_ANTIWINDUP  = 3'd5;
	localparam logic [2:0] REG_TRIG_THRESH = 3'd6;
	localparam logic [2:0] REG_TRIG_HYST   = 3'd7;

	localparam int APB_AW    = 5;
	localparam int APB_DW    = 32;
	localparam int GAIN_W    = 24;
	localparam int GAIN_FRAC = 20;
	localparam int LIMIT_W   = 32;
	localparam int OUT_W     = 32;
	localparam int THR_W     = 16;

	localparam logic signed [GAIN_W-1:0]  GAIN_STEP_RST   = 24'sh10_0000;
	localparam logic signed [LIMIT_W-1:0] LOWER_LIMIT_RST = 32'sh8000_0000;
	localparam logic signed [LIMIT_W-1:0] UPPER_LIMIT_RST = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [1:0]                reset_mode;
		logic signed [LIMIT_W-1:0] reset_value;
		logic signed [GAIN_W-1:0]  gain_step;
		logic signed [LIMIT_W-1:0] lower_limit;
		logic signed [LIMIT_W-1:0] upper_limit;
		logic                      antiwindup_on;
		logic signed [THR_W-1:0]   trigger_threshold;
		logic [THR_W-1:0]          trigger_hysteresis;
	} cfg_t;

endpackage

### hdl/integrator_with_trigger_reset.sv
// Channel | Dir | Signals                          | Contents
// s_*     | in  | s_tvalid s_tready s_tdata s_tuser | samples + command
// m_*     | out | m_tvalid m_tready m_tdata m_tuser | integral + trigger flags
// apb     | in  | psel penable pwrite paddr pwdata  | configuration registers
//
// One transaction per clock sustained on both streams while m_tready stays high.
// Two stages: input register (multiply, trigger compares), then the state
// update and result register; an accepted sample passes through both in turn.
// The result register parts the two sides: the next input is taken while a
// result waits, and s_tready only drops when both stages are full.
// arst_n clears the integral, trigger state and valids, and sets the registers to their defaults.
module integrator_with_trigger_reset import itr_pkg::*; #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACC_WIDTH    = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// input stream
	input  logic              s_tvalid,
	output logic              s_tready,
	// [SAMPLE_WIDTH-1:0] signal_sample, [2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] trigger_sample
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	// [1:0] command
	input  logic [1:0]        s_tuser,
	// output stream
	output logic              m_tvalid,
	input  logic              m_tready,
	// [31:0] integral_out
	output logic [OUT_W-1:0]  m_tdata,
	// [0] trigger_level, [1] reset_taken
	output logic [1:0]        m_tuser,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

`include "integrator_with_trigger_reset_assert.svh"

	localparam int PROD_W = SAMPLE_WIDTH + GAIN_W;
	localparam int INC_W  = PROD_W - GAIN_FRAC;
	// the integral can hold an unclamped reset_value, so keep at least 32 bits
	localparam int INT_W  = (ACC_WIDTH > LIMIT_W) ? ACC_WIDTH : LIMIT_W;
	localparam int SUM_W  = ((INT_W > INC_W) ? INT_W : INC_W) + 2;
	localparam int TRIG_W = ((SAMPLE_WIDTH > THR_W) ? SAMPLE_WIDTH : THR_W) + 3;

	// accumulator saturation bounds, extended to the sum width
	localparam logic signed [SUM_W-1:0] ACC_MAX =
		{{(SUM_W-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;

	cfg_t cfg;

	itr_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// ---------------- stage 1: input register ----------------
	logic signed [SAMPLE_WIDTH-1:0] sig_in, trig_in;
	logic signed [PROD_W-1:0]       prod_c;
	logic signed [TRIG_W-1:0]       raw2_c, ctr2_c, hyst_c;
	logic                           rise_c, stay_c;

	logic                     valid_s1;
	logic [1:0]               cmd_s1;
	logic signed [PROD_W-1:0] prod_s1;
	logic                     rise_s1, stay_s1;
	logic                     advance;

	assign sig_in  = signed'(s_tdata[SAMPLE_WIDTH-1:0]);
	assign trig_in = signed'(s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]);

	// product only depends on the sample and gain, so it is taken ahead of the state
	assign prod_c = PROD_W'(sig_in) * PROD_W'(cfg.gain_step);

	// Schmitt compares in doubled units, no rounding of hysteresis/2
	assign raw2_c = TRIG_W'(trig_in) <<< 1;
	assign ctr2_c = TRIG_W'(cfg.trigger_threshold) <<< 1;
	assign hyst_c = signed'(TRIG_W'(cfg.trigger_hysteresis));
	assign rise_c = raw2_c >= (ctr2_c + hyst_c);
	assign stay_c = raw2_c >  (ctr2_c - hyst_c);

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= s_tuser;
			prod_s1 <= prod_c;
			rise_s1 <= rise_c;
			stay_s1 <= stay_c;
		end
	end

	// ---------------- stage 2: state update ----------------
	logic signed [INT_W-1:0] integral_q;
	logic                    trig_state_q;

	logic                    is_step, is_init;
	logic                    high_c, fire_c, edge_hit;
	logic                    prod_pos, prod_neg, aw_block;
	logic signed [INC_W-1:0] inc_c;
	logic signed [SUM_W-1:0] int_x, lo_x, hi_x, inc_x, sum_c, sat_c, clamp_c;
	logic signed [INT_W-1:0] next_int;

	assign is_step = (cmd_s1 == CMD_STEP);
	assign is_init = (cmd_s1 == CMD_INIT);

	// initialize evaluates the trigger as if it had been low
	assign high_c = (trig_state_q && !is_init) ? stay_s1 : rise_s1;

	always_comb begin
		case (cfg.reset_mode)
			RM_LEVEL: edge_hit = high_c;
			RM_RISE:  edge_hit = !trig_state_q && high_c;
			RM_FALL:  edge_hit = trig_state_q && !high_c;
			default:  edge_hit = 1'b0;
		endcase
	end
	assign fire_c = is_step && edge_hit;

	// arithmetic shift right by the fraction bits == upper slice of the product
	assign inc_c    = signed'(prod_s1[PROD_W-1:GAIN_FRAC]);
	assign prod_neg = prod_s1[PROD_W-1];
	assign prod_pos = !prod_neg && (|prod_s1);

	assign int_x = SUM_W'(integral_q);
	assign lo_x  = SUM_W'(cfg.lower_limit);
	assign hi_x  = SUM_W'(cfg.upper_limit);

	// anti-windup: no push further past a limit already reached
	assign aw_block = cfg.antiwindup_on &&
		(((int_x >= hi_x) && prod_pos) || ((int_x <= lo_x) && prod_neg));
	assign inc_x = aw_block ? '0 : SUM_W'(inc_c);
	assign sum_c = int_x + inc_x;

	always_comb begin
		if (sum_c > ACC_MAX) begin
			sat_c = ACC_MAX;
		end else if (sum_c < ACC_MIN) begin
			sat_c = ACC_MIN;
		end else begin
			sat_c = sum_c;
		end
		// when the limits cross, a value below the lower limit takes it, any other the upper
		if (sat_c < lo_x) begin
			clamp_c = lo_x;
		end else if (sat_c > hi_x) begin
			clamp_c = hi_x;
		end else begin
			clamp_c = sat_c;
		end
	end

	always_comb begin
		if (is_init || fire_c) begin
			next_int = INT_W'(cfg.reset_value);
		end else if (is_step) begin
			next_int = INT_W'(clamp_c);
		end else begin
			next_int = integral_q;   // hold and unused command
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q   <= '0;
			trig_state_q <= 1'b0;
		end else if (advance) begin
			integral_q   <= next_int;
			trig_state_q <= high_c;
		end
	end

	// ---------------- result register ----------------
	logic                   valid_s2;
	logic [OUT_W-1:0]       integral_s2;
	logic                   level_s2, took_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			integral_s2 <= next_int[OUT_W-1:0];
			level_s2    <= high_c;
			took_s2     <= fire_c;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = integral_s2;
	assign m_tuser  = {took_s2, level_s2};

	// ---------------- assertions ----------------
	`ITR_ASSERT_IMP(a_full_pipe_stalls, clk, arst_n, valid_s1 && m_tvalid && !m_tready, !s_tready)
	`ITR_ASSERT_NXT(a_advance_shows, clk, arst_n, advance, m_tvalid)
	`ITR_ASSERT_NXT(a_fire_loads, clk, arst_n, advance && fire_c, integral_q == INT_W'($past(cfg.reset_value)))
	`ITR_ASSERT_NXT(a_step_in_limits, clk, arst_n, advance && is_step && !fire_c && (lo_x <= hi_x), (SUM_W'(integral_q) >= $past(lo_x)) && (SUM_W'(integral_q) <= $past(hi_x)))

endmodule

### hdl/itr_apb_regs.sv
module itr_apb_regs import itr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	logic [1:0]                reset_mode_q;
	logic signed [LIMIT_W-1:0] reset_value_q;
	logic signed [GAIN_W-1:0]  gain_step_q;
	logic signed [LIMIT_W-1:0] lower_limit_q;
	logic signed [LIMIT_W-1:0] upper_limit_q;
	logic                      antiwindup_q;
	logic signed [THR_W-1:0]   trig_thresh_q;
	logic [THR_W-1:0]          trig_hyst_q;
	logic [2:0]                reg_idx;
	logic                      wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_AW-1:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_mode_q  <= RM_LEVEL;
			reset_value_q <= '0;
			gain_step_q   <= GAIN_STEP_RST;
			lower_limit_q <= LOWER_LIMIT_RST;
			upper_limit_q <= UPPER_LIMIT_RST;
			antiwindup_q  <= 1'b0;
			trig_thresh_q <= '0;
			trig_hyst_q   <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RESET_MODE:  reset_mode_q  <= pwdata[1:0];
				REG_RESET_VALUE: reset_value_q <= signed'(pwdata[LIMIT_W-1:0]);
				REG_GAIN_STEP:   gain_step_q   <= signed'(pwdata[GAIN_W-1:0]);
				REG_LOWER_LIMIT: lower_limit_q <= signed'(pwdata[LIMIT_W-1:0]);
				REG_UPPER_LIMIT: upper_limit_q <= signed'(pwdata[LIMIT_W-1:0]);
				REG_ANTIWINDUP:  antiwindup_q  <= pwdata[0];
				REG_TRIG_THRESH: trig_thresh_q <= signed'(pwdata[THR_W-1:0]);
				REG_TRIG_HYST:   trig_hyst_q   <= pwdata[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// signed registers read back sign-extended
	always_comb begin
		unique case (reg_idx)
			REG_RESET_MODE:  prdata = APB_DW'(reset_mode_q);
			REG_RESET_VALUE: prdata = APB_DW'(reset_value_q);
			REG_GAIN_STEP:   prdata = APB_DW'(gain_step_q);
			REG_LOWER_LIMIT: prdata = APB_DW'(lower_limit_q);
			REG_UPPER_LIMIT: prdata = APB_DW'(upper_limit_q);
			REG_ANTIWINDUP:  prdata = APB_DW'(antiwindup_q);
			REG_TRIG_THRESH: prdata = APB_DW'(trig_thresh_q);
			REG_TRIG_HYST:   prdata = APB_DW'(trig_hyst_q);
			default:         prdata = '0;
		endcase
	end

	assign cfg.reset_mode         = reset_mode_q;
	assign cfg.reset_value        = reset_value_q;
	assign cfg.gain_step          = gain_step_q;
	assign cfg.lower_limit        = lower_limit_q;
	assign cfg.upper_limit        = upper_limit_q;
	assign cfg.antiwindup_on      = antiwindup_q;
	assign cfg.trigger_threshold  = trig_thresh_q;
	assign cfg.trigger_hysteresis = trig_hyst_q;

endmodule
